@@ hw/rtl/bwo_pkg.sv @@
// shared types and constants of the band-limited wavetable oscillator
`default_nettype none

package bwo_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_GEN   = 1'b1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;
    localparam int BAND_W     = 4;
    localparam int INC_W      = 41;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_PER_HZ    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BAND    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLES_IN_USE = 8'd3;

    localparam logic [31:0] MAX_FREQ_RST   = 32'd1572864000;
    localparam logic [39:0] INC_PER_HZ_RST = 40'd5864062015;
    localparam logic [31:0] FIRST_BAND_RST = 32'd2796203;
    localparam logic [3:0]  TABLES_RST     = 4'd11;

    localparam logic [31:0] FREQ_FLOOR_Q16 = 32'd655360;

    typedef struct packed {
        logic [31:0]       max_freq;
        logic [31:0]       inc_lo;
        logic [7:0]        inc_hi;
        logic [31:0]       first_band_top;
        logic [BAND_W-1:0] last_band;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/bwo_ifs.sv @@
// handshake channels of the oscillator: command items, result items, register writes
`default_nettype none

interface bwo_in_if
    import bwo_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] freq_hz_q16;
    logic [3:0]  table_number;
    logic [10:0] table_address;
    logic signed [15:0] table_word;

    modport source (output valid, command, freq_hz_q16, table_number, table_address,
                    table_word, input ready);
    modport sink   (input valid, command, freq_hz_q16, table_number, table_address,
                    table_word, output ready);
endinterface

interface bwo_out_if
    import bwo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic signed [15:0] sample_out;
    logic [BAND_W-1:0] band_used;

    modport source (output valid, sample_out, band_used, input ready);
    modport sink   (input valid, sample_out, band_used, output ready);
endinterface

interface bwo_cfg_if
    import bwo_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bwo_mul.sv @@
// shared registered 32x32 multiplier
`default_nettype none

module bwo_mul
    import bwo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bwo_wave_mem.sv @@
// wavetable store, one write and one registered read port
`default_nettype none

module bwo_wave_mem
    import bwo_pkg::*;
#(
    parameter int DEPTH = 22528,
    parameter int AW    = 15
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bwo_seq.sv @@
// sequencer: clamp, increment, phase, band search, table read and result register
`default_nettype none

module bwo_seq
    import bwo_pkg::*;
#(
    parameter int TABLE_LEN = 2048,
    parameter int NUM_BANDS = 11,
    parameter int MEM_AW    = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    bwo_in_if.sink                 in_ch,
    bwo_out_if.source              out_ch,
    output logic                   mul_en,
    output logic      [31:0]       mul_a,
    output logic      [31:0]       mul_b,
    input  wire logic [63:0]       mul_prod,
    output logic                   rd_en,
    output logic      [MEM_AW-1:0] rd_addr,
    input  wire logic [15:0]       rd_data
);

    localparam int IDX_W = $clog2(TABLE_LEN);
    localparam int TOP_W = 32 + NUM_BANDS - 1;
    localparam int CMP_W = (TOP_W > INC_W) ? TOP_W : INC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_PHASE,
        S_MUL_IDX,
        S_BAND,
        S_ADDR,
        S_READ,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         freq_reg, freq_next;
    logic [INC_W-1:0]    inc_reg, inc_next;
    logic [31:0]         phase_reg, phase_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [BAND_W-1:0]   band_reg, band_next;
    logic [MEM_AW-1:0]   addr_reg, addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         sample_reg, sample_next;
    logic [BAND_W-1:0]   band_out_reg, band_out_next;

    logic [31:0]         freq_lim;
    logic [31:0]         freq_clamp;
    logic [IDX_W-1:0]    idx;
    logic                band_hit;

    always_comb
    begin
        freq_lim   = (in_ch.freq_hz_q16 > cfg.max_freq) ? cfg.max_freq : in_ch.freq_hz_q16;
        freq_clamp = (freq_lim < FREQ_FLOOR_Q16) ? FREQ_FLOOR_Q16 : freq_lim;
        idx        = mul_prod[32 +: IDX_W];
        band_hit   = CMP_W'(inc_reg) < CMP_W'(top_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        freq_next      = freq_reg;
        inc_next       = inc_reg;
        phase_next     = phase_reg;
        top_next       = top_reg;
        band_next      = band_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        band_out_next  = band_out_reg;
        mul_en         = 1'b0;
        mul_a          = freq_reg;
        mul_b          = cfg.inc_lo;
        rd_en          = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.command == CMD_GEN)
                begin
                    freq_next  = freq_clamp;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                mul_en     = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                mul_en     = 1'b1;
                mul_b      = {24'd0, cfg.inc_hi};
                inc_next   = INC_W'(mul_prod[63:32]);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                inc_next   = inc_reg + INC_W'(mul_prod[39:0]);
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                phase_next = phase_reg + inc_reg[31:0];
                top_next   = TOP_W'(cfg.first_band_top);
                band_next  = '0;
                state_next = S_MUL_IDX;
            end
            S_MUL_IDX:
            begin
                mul_en     = 1'b1;
                mul_a      = phase_reg;
                mul_b      = 32'(TABLE_LEN - 1);
                state_next = S_BAND;
            end
            S_BAND:
            begin
                if (band_hit || band_reg == cfg.last_band)
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    band_next = band_reg + BAND_W'(1);
                    top_next  = {top_reg[TOP_W-2:0], 1'b0};
                end
            end
            S_ADDR:
            begin
                addr_next  = MEM_AW'(32'(band_reg) * TABLE_LEN) + MEM_AW'(idx);
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = rd_data;
                    band_out_next  = band_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg     <= freq_next;
        inc_reg      <= inc_next;
        top_reg      <= top_next;
        band_reg     <= band_next;
        addr_reg     <= addr_next;
        sample_reg   <= sample_next;
        band_out_reg <= band_out_next;
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign rd_addr           = addr_reg;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_reg;
    assign out_ch.band_used  = band_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bandlimited_wavetable_oscillator.sv @@
// band-limited wavetable oscillator: sample generation with per-octave table choice
// a table write item is taken every cycle while idle, registered, then written to the store
// a generate item runs increment multiply and add, phase, index multiply, band search one
// band at a time, address, read and result register before another item is taken
// reset loads the register defaults and clears phase; tables are undefined until written
`default_nettype none

module bandlimited_wavetable_oscillator
    import bwo_pkg::*;
#(
    parameter int TABLE_LEN = 2048,
    parameter int NUM_BANDS = 11
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bwo_in_if.sink    in_ch,
    bwo_out_if.source out_ch,
    bwo_cfg_if.sink   cfg_ch
);

    localparam int MEM_DEPTH = NUM_BANDS * TABLE_LEN;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic [31:0]       max_freq_reg;
    logic [39:0]       inc_per_hz_reg;
    logic [31:0]       first_band_reg;
    logic [3:0]        tables_reg;
    cfg_t              cfg;
    logic [BAND_W-1:0] last_band;

    logic              wr_en_reg;
    logic [MEM_AW-1:0] wr_addr_reg;
    logic [15:0]       wr_data_reg;
    logic              wr_ok;

    logic              mul_en;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_prod;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [15:0]       rd_data;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_freq_reg   <= MAX_FREQ_RST;
            inc_per_hz_reg <= INC_PER_HZ_RST;
            first_band_reg <= FIRST_BAND_RST;
            tables_reg     <= TABLES_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_MAX_FREQ:      max_freq_reg   <= cfg_ch.data[31:0];
                REG_INC_PER_HZ:    inc_per_hz_reg <= cfg_ch.data[39:0];
                REG_FIRST_BAND:    first_band_reg <= cfg_ch.data[31:0];
                REG_TABLES_IN_USE: tables_reg     <= cfg_ch.data[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (tables_reg == 4'd0)
        begin
            last_band = '0;
        end
        else if ({1'b0, tables_reg} > 5'(NUM_BANDS))
        begin
            last_band = BAND_W'(NUM_BANDS - 1);
        end
        else
        begin
            last_band = BAND_W'(tables_reg - 4'd1);
        end
        cfg.max_freq       = max_freq_reg;
        cfg.inc_lo         = inc_per_hz_reg[31:0];
        cfg.inc_hi         = inc_per_hz_reg[39:32];
        cfg.first_band_top = first_band_reg;
        cfg.last_band      = last_band;
    end

    // table word writes
    assign wr_ok = in_ch.valid && in_ch.ready && in_ch.command == CMD_WRITE
                   && (32'(in_ch.table_number) < 32'(NUM_BANDS))
                   && (32'(in_ch.table_address) < 32'(TABLE_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
        end
        else
        begin
            wr_en_reg <= wr_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= MEM_AW'(32'(in_ch.table_number) * TABLE_LEN)
                       + MEM_AW'(in_ch.table_address);
        wr_data_reg <= in_ch.table_word;
    end

    bwo_seq #(
        .TABLE_LEN (TABLE_LEN),
        .NUM_BANDS (NUM_BANDS),
        .MEM_AW    (MEM_AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    bwo_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    bwo_wave_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> 32'(out_ch.band_used) < 32'(NUM_BANDS))
        else $error("band out of range");

    a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.command == CMD_WRITE |=> in_ch.ready)
        else $error("write item stalled input");

    a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.command == CMD_GEN |=> !in_ch.ready)
        else $error("generate item did not start sequence");

    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> 32'(wr_addr_reg) < 32'(MEM_DEPTH))
        else $error("table write beyond store");

endmodule

`default_nettype wire
